/* src/cfrc_pkg.sv */
// Shared types, constants and helper functions for the command frame
// receive check block. No dependencies.
`default_nettype none

package cfrc_pkg;

  // Frame delimiters and special ids
  localparam logic [7:0] STX_BYTE     = 8'h02;
  localparam logic [7:0] ETX_BYTE     = 8'h03;
  localparam logic [7:0] BCAST_ID     = 8'hff;
  localparam logic [7:0] MIN_LEN      = 8'd8;
  localparam logic [7:0] ADDR_RST_VAL = 8'h01;

  // Frame status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_ADDR  = 3'd2,
    ST_END   = 3'd3,
    ST_SUM   = 3'd4
  } status_t;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One input item
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } item_t;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    status_t    status;
  } result_t;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] nib8;
    nib8 = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + nib8;
    end else begin
      hex_char = 8'h37 + nib8;
    end
  endfunction

endpackage

`default_nettype wire

/* src/command_frame_receive_check_core.sv */
// Top level of the command frame receive check: input register, frame check
// logic and result register. Depends on cfrc_pkg and the cfrc_* modules.
`default_nettype none

// Checks STX/ETX command frames arriving one byte per item. The block takes
// one byte every clock cycle while in_stall is low; each byte is decoded
// combinationally between the input register and the result register. A byte
// is captured in the input register, and its result is loaded into the result
// register as the byte moves on; a full result register can hold it back. A
// result held by out_stall keeps the next byte that has a result in the input
// register, which then stalls the input until the result register drains.
// Payload bytes come out as they arrive, and each started frame ends with one
// status item. Byte position and running sum update as each byte moves on.
// The address register may be written only while no byte is in flight.

module command_frame_receive_check_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_buffer_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_result_kind,
  output logic [7:0]      out_command,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [2:0]      out_status
);
  import cfrc_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_free;

  assign in_item.rx_byte    = in_rx_byte;
  assign in_item.buffer_end = in_buffer_end;

  // Input register
  cfrc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Frame state and checks
  cfrc_frame_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_free  (out_free),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  cfrc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_result_kind   = out_res.kind;
  assign out_command       = out_res.command;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_status        = out_res.status;

  // A result never overwrites one that is still held
  a_no_ovwr: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |-> out_free)
    else $error("result register overwritten");

  // Payload items always carry an OK status
  a_pay_st: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.kind == KIND_PAYLOAD) |-> (out_res.status == ST_OK))
    else $error("payload item with nonzero status");

  // Input stalls only when a byte is waiting in the input register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && res_valid && !out_free))
    else $error("unexpected input stall");

endmodule

`default_nettype wire

/* src/cfrc_in_stage.sv */
// Input register of the frame check: captures one item per cycle unless stalled.
// Depends on cfrc_pkg.
`default_nettype none

module cfrc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire cfrc_pkg::item_t in_item,
  output logic                in_stall,
  input  wire logic           advance,
  output logic                s1_valid,
  output cfrc_pkg::item_t     s1_item
);
  import cfrc_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;

  // Hold the register while its item cannot move on
  assign in_stall = s1_valid_r && !advance;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* src/cfrc_frame_check.sv */
// Frame tracking state and per-byte check logic, plus the address register.
// Depends on cfrc_pkg.
`default_nettype none

module cfrc_frame_check (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            s1_valid,
  input  wire cfrc_pkg::item_t s1_item,
  input  wire logic            out_free,
  output logic                 advance,
  output logic                 res_valid,
  output cfrc_pkg::result_t    res
);
  import cfrc_pkg::*;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] len;
    logic [7:0] id;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic       hex_ok;
    logic       active;
    logic       finished;
  } fstate_t;

  fstate_t    st_r, st_nxt;
  logic [7:0] dev_addr_r;

  logic [7:0] b;
  logic       is_end;
  logic       body;
  logic       status_out;
  status_t    st_code;
  logic       pay_out;

  assign b      = s1_item.rx_byte;
  assign is_end = s1_item.buffer_end;

  // Per-byte decode and next state
  always_comb begin
    st_nxt     = st_r;
    status_out = 1'b0;
    st_code    = ST_OK;
    pay_out    = 1'b0;
    body       = 1'b0;

    if (st_r.finished) begin
      // rest of buffer ignored
    end else if (!st_r.active) begin
      if (b == STX_BYTE) begin
        st_nxt.active = 1'b1;
        st_nxt.pos    = 8'd1;
        if (is_end) begin
          status_out = 1'b1;
          st_code    = ST_SHORT;
        end
      end else begin
        st_nxt.finished = 1'b1;
      end
    end else begin
      if (st_r.pos == 8'd1) begin
        st_nxt.len = b;
        st_nxt.sum = b;
        if (b < MIN_LEN) begin
          status_out = 1'b1;
          st_code    = ST_SHORT;
        end
      end else begin
        // len is at least MIN_LEN here, so len-4 does not wrap
        body = (st_r.pos <= st_r.len - 8'd4);
        if (body) begin
          st_nxt.sum = st_r.sum + b;
        end
        if (st_r.pos == 8'd3) begin
          st_nxt.id = b;
        end
        if (st_r.pos == 8'd4) begin
          st_nxt.cmd = b;
        end
        if (st_r.pos >= 8'd5 && body) begin
          pay_out = 1'b1;
        end else if (st_r.pos == st_r.len - 8'd3) begin
          st_nxt.hex_ok = (b == hex_char(st_r.sum[7:4]));
        end else if (st_r.pos == st_r.len - 8'd2) begin
          st_nxt.hex_ok = st_r.hex_ok && (b == hex_char(st_r.sum[3:0]));
        end else if (st_r.pos == st_r.len - 8'd1) begin
          status_out = 1'b1;
          if (st_r.id != BCAST_ID && st_r.id != dev_addr_r) begin
            st_code = ST_ADDR;
          end else if (st_r.id != BCAST_ID && b != ETX_BYTE) begin
            st_code = ST_END;
          end else if (!st_r.hex_ok) begin
            st_code = ST_SUM;
          end else begin
            st_code = ST_OK;
          end
        end
      end

      // early buffer end overrides a payload result
      if (!status_out && is_end) begin
        status_out = 1'b1;
        st_code    = ST_SHORT;
      end
      if (status_out) begin
        st_nxt.active   = 1'b0;
        st_nxt.finished = 1'b1;
      end else begin
        st_nxt.pos = st_r.pos + 8'd1;
      end
    end

    // Result from this byte, command after this byte's update
    res_valid         = status_out || pay_out;
    res.command       = st_nxt.cmd;
    res.kind          = status_out ? KIND_STATUS : KIND_PAYLOAD;
    res.payload_byte  = status_out ? 8'h00 : b;
    res.payload_index = status_out ? 8'h00 : (st_r.pos - 8'd5);
    res.status        = status_out ? st_code : ST_OK;

    // buffer end clears all frame state
    if (is_end) begin
      st_nxt = '0;
    end
  end

  // Byte moves on unless its result finds the output register full
  assign advance = s1_valid && (!res_valid || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      dev_addr_r <= ADDR_RST_VAL;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_we) begin
        dev_addr_r <= cfg_wdata;
      end
    end
  end

  // A frame is never both in progress and done
  a_act_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.active && st_r.finished))
    else $error("frame active and finished together");

  // Past the length byte, a live frame always has a legal length
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.active && st_r.pos > 8'd1) |-> (st_r.len >= MIN_LEN))
    else $error("active frame with short length");

  // Position stays below the end of a maximal frame
  a_pos_rng: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> (st_r.pos != 8'hff))
    else $error("byte position overflow");

endmodule

`default_nettype wire

/* src/cfrc_out_stage.sv */
// Result register of the frame check: holds one result until taken.
// Depends on cfrc_pkg.
`default_nettype none

module cfrc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire cfrc_pkg::result_t res,
  input  wire logic              out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output cfrc_pkg::result_t      out_res
);
  import cfrc_pkg::*;

  logic    out_valid_r;
  result_t out_res_r;

  // Register can take a new result when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_res_r <= res;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_command_frame_receive_check_core.sv */
// Testbench for command_frame_receive_check_core: drives whole receive buffers,
// predicts payload and status items in a scoreboard class and checks each one.
// Depends on cfrc_pkg and the RTL top level only.
`default_nettype none

module tb_command_frame_receive_check_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cfrc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int DRAIN_CYCLES = 6;

  // Predicts the frame check and holds the items still owed by the block
  class frame_scoreboard;
    logic [7:0] dev_addr;
    int pos;
    int flen;
    logic [7:0] fid;
    logic [7:0] fcmd;
    logic [7:0] fsum;
    bit hex_ok;
    bit active;
    bit finished;
    result_t owed[$];
    int errors;

    function new();
      dev_addr = ADDR_RST_VAL;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos = 0;
      flen = 0;
      fid = '0;
      fcmd = '0;
      fsum = '0;
      hex_ok = 0;
      active = 0;
      finished = 0;
    endfunction

    function void set_address(logic [7:0] a);
      dev_addr = a;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic [7:0] hex_digit(logic [3:0] nib);
      if (nib > 4'd9) return ASCII_UPPER_A + 8'(nib - 4'd10);
      return ASCII_ZERO + 8'(nib);
    endfunction

    // Advance the frame state by one accepted byte; returns 1 if the byte
    // belonged to a started frame (ignored bytes return 0)
    function bit note_input(logic [7:0] b, logic last);
      result_t r;
      status_t st;
      bit give_status;
      bit give_payload;
      bit counted;
      int p;
      int len;
      give_status = 0;
      give_payload = 0;
      st = ST_OK;
      counted = !finished && (active || b == STX_BYTE);
      r = '0;
      if (finished) begin
        // rest of buffer ignored
      end else if (!active) begin
        if (b == STX_BYTE) begin
          active = 1;
          pos = 1;
          if (last) begin
            give_status = 1;
            st = ST_SHORT;
          end
        end else begin
          finished = 1;
        end
      end else begin
        p = pos;
        len = flen;
        if (p == 1) begin
          flen = int'(b);
          fsum = b;
          if (b < MIN_LEN) begin
            give_status = 1;
            st = ST_SHORT;
          end
        end else begin
          if (p <= len - 4) fsum = fsum + b;
          if (p == 3) fid = b;
          if (p == 4) fcmd = b;
          if (p >= 5 && p <= len - 4) begin
            give_payload = 1;
            r.payload_byte = b;
            r.payload_index = 8'(p - 5);
          end else if (p == len - 3) begin
            hex_ok = (b == hex_digit(fsum[7:4]));
          end else if (p == len - 2) begin
            hex_ok = hex_ok && (b == hex_digit(fsum[3:0]));
          end else if (p == len - 1) begin
            // address first, then end byte, then checksum; broadcast
            // only checks the checksum
            give_status = 1;
            if (fid != BCAST_ID && fid != dev_addr) st = ST_ADDR;
            else if (fid != BCAST_ID && b != ETX_BYTE) st = ST_END;
            else if (!hex_ok) st = ST_SUM;
            else st = ST_OK;
          end
        end
        // buffer ended early: status replaces any payload item
        if (!give_status && last) begin
          give_status = 1;
          st = ST_SHORT;
        end
        if (give_status) begin
          active = 0;
          finished = 1;
        end else begin
          pos = p + 1;
        end
      end

      if (give_status) begin
        r.kind = KIND_STATUS;
        r.command = fcmd;
        r.payload_byte = '0;
        r.payload_index = '0;
        r.status = st;
        owed.push_back(r);
      end else if (give_payload) begin
        r.kind = KIND_PAYLOAD;
        r.command = fcmd;
        r.status = ST_OK;
        owed.push_back(r);
      end
      if (last) clear_frame();
      return counted;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result item with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected item kind=%0d cmd=%02h byte=%02h idx=%0d st=%0d",
                       got.kind, got.command, got.payload_byte, got.payload_index,
                       got.status));
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind || got.command !== want.command ||
          got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index || got.status !== want.status) begin
        flag($sformatf({"mismatch exp kind=%0d cmd=%02h byte=%02h idx=%0d st=%0d",
                        " got kind=%0d cmd=%02h byte=%02h idx=%0d st=%0d"},
                       want.kind, want.command, want.payload_byte, want.payload_index,
                       want.status, got.kind, got.command, got.payload_byte,
                       got.payload_index, got.status));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = '0;
  logic in_buffer_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic [7:0] out_command;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [2:0] out_status;

  frame_scoreboard sb = new();
  bit calm = 0;
  int frame_bytes = 0;

  command_frame_receive_check_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .in_buffer_end(in_buffer_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_kind(out_result_kind),
    .out_command(out_command),
    .out_payload_byte(out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 23);
  endfunction

  // Result side: check accepted items, stall at random
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_result_kind;
      got.command = out_command;
      got.payload_byte = out_payload_byte;
      got.payload_index = out_payload_index;
      got.status = status_t'(out_status);
      sb.check_result(got);
    end
    out_stall <= roll_idle();
  end

  // Random payload byte, leaning on the extremes now and then
  function automatic logic [7:0] rand_data();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // Build one frame; the checksum can be spoiled in either digit
  function automatic byte_q_t make_frame(int len, logic [7:0] id, logic [7:0] cmd,
                                         bit sum_ok, logic [7:0] end_byte, int trail);
    byte_q_t q;
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    q.push_back(STX_BYTE);
    q.push_back(8'(len));
    q.push_back(8'($urandom_range(255)));
    q.push_back(id);
    q.push_back(cmd);
    for (int p = 5; p <= len - 4; p++) q.push_back(rand_data());
    sum = '0;
    for (int i = 1; i < q.size(); i++) sum = sum + q[i];
    hi = sb.hex_digit(sum[7:4]);
    lo = sb.hex_digit(sum[3:0]);
    if (!sum_ok) begin
      case ($urandom_range(2))
        0: hi = hi ^ 8'h20;
        1: lo = lo ^ 8'h20;
        default: hi = 8'($urandom_range(255));
      endcase
    end
    q.push_back(hi);
    q.push_back(lo);
    q.push_back(end_byte);
    repeat (trail) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // Send one item and wait for it to be taken
  task automatic send_item(logic [7:0] b, logic last);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_buffer_end <= last;
    do @(posedge clk); while (in_stall);
    if (sb.note_input(b, last)) frame_bytes++;
  endtask

  // Send a whole receive buffer, marking its last byte
  task automatic send_buffer(byte_q_t q);
    for (int i = 0; i < q.size(); i++) send_item(q[i], i == q.size() - 1);
  endtask

  // Hold the sender until every owed item has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] a);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_address(a);
  endtask

  // One random buffer: mostly well-formed frames, some noise and broken ones
  task automatic send_random_buffer();
    byte_q_t q;
    int r;
    int len;
    int k;
    logic [7:0] id;
    logic [7:0] etx;
    r = $urandom_range(99);
    if (r < 6) begin
      repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(255)));
    end else if (r < 10) begin
      q.push_back(STX_BYTE);
      q.push_back(8'($urandom_range(7)));
      repeat ($urandom_range(2)) q.push_back(8'($urandom_range(255)));
    end else if (r < 12) begin
      q.push_back(STX_BYTE);
    end else begin
      k = $urandom_range(99);
      if (k < 1) len = 255;
      else if (k < 3) len = $urandom_range(200, 254);
      else len = $urandom_range(8, 24);
      k = $urandom_range(99);
      if (k < 60) id = sb.dev_addr;
      else if (k < 75) id = BCAST_ID;
      else id = 8'($urandom_range(255));
      etx = ($urandom_range(99) < 88) ? ETX_BYTE : 8'($urandom_range(255));
      q = make_frame(len, id, rand_data(), $urandom_range(99) < 85, etx,
                     ($urandom_range(1) != 0) ? $urandom_range(1, 3) : 0);
      // buffer cut short somewhere inside the frame
      if ($urandom_range(99) < 10) begin
        k = $urandom_range(2, q.size() - 1);
        q = q[0:k-1];
      end
    end
    send_buffer(q);
  endtask

  // Run limit
  initial begin
    #(3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] addrs[5];
    addrs[0] = 8'h00;
    addrs[1] = 8'hff;
    addrs[2] = 8'($urandom_range(255));
    addrs[3] = ADDR_RST_VAL;
    addrs[4] = 8'($urandom_range(255));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers at the reset address
    send_buffer('{STX_BYTE});
    send_buffer('{8'h55, STX_BYTE});
    send_buffer('{STX_BYTE, 8'd7, 8'haa});
    send_buffer(make_frame(8, ADDR_RST_VAL, 8'hff, 1, ETX_BYTE, 0));
    send_buffer(make_frame(9, BCAST_ID, 8'h00, 1, 8'h00, 1));
    send_buffer('{STX_BYTE, 8'd10, 8'h01});
    drain();

    // Random phases, one address setting each; one phase runs without gaps
    for (int ph = 0; ph < 5; ph++) begin
      write_address(addrs[ph]);
      calm = (ph == 2);
      frame_bytes = 0;
      while (frame_bytes < ITEMS_PER_PHASE) send_random_buffer();
      drain();
    end
    calm = 0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/cfrc_pkg.sv
src/cfrc_in_stage.sv
src/cfrc_frame_check.sv
src/cfrc_out_stage.sv
src/command_frame_receive_check_core.sv
verif/tb_command_frame_receive_check_core.sv
